@@ rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, status codes, register indexes and the command/status
// bundles that join the pool controller and the pool datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  // field widths
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int COUNT_W   = 11;
  // offset inside the pool is below count * size
  localparam int REM_W     = COUNT_W + SIZE_W;
  localparam int STEP_W    = $clog2(COUNT_W);
  localparam int CFG_IDX_W = 2;

  // defaults and reset values
  localparam int MAX_BLOCKS_DEF = 1024;
  localparam int COUNT_RST      = 1024;
  localparam int SIZE_RST       = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  // request type
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FREED    = 3'd2,
    ST_NULL     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_MISALIGN = 3'd5,
    ST_DUP      = 3'd6,
    ST_FULL     = 3'd7
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    mul_count;
    logic    mul_entry;
    logic    set_addr;
    logic    div_start;
    logic    scan_start;
    logic    scan_step;
    logic    pop;
    logic    push;
    logic    load_result;
    status_e code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_free;
    logic is_null;
    logic out_range;
    logic div_done;
    logic misalign;
    logic scan_hit;
    logic scan_end;
    logic stack_full;
    logic stack_empty;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/fbpa_divider.sv @@
// ----------------------------------------------------------------------------
// fbpa_divider
// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2**COUNT_W, so the quotient fits COUNT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_divider (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [fbpa_pkg::REM_W-1:0]    dividend_i,
  input  wire [fbpa_pkg::SIZE_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [fbpa_pkg::COUNT_W-1:0] quotient_o,
  output logic                         rem_zero_o
);
  import fbpa_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [COUNT_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0]   shifted;
  logic [REM_W-1:0]   trial;
  logic               fits;

  // trial subtract of the shifted divisor
  assign shifted = REM_W'(divisor_i) << step_q;
  assign fits    = rem_q >= shifted;
  assign trial   = rem_q - shifted;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = STEP_W'(COUNT_W - 1);
      rem_d  = dividend_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d         = trial;
        quo_d[step_q] = 1'b1;
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

`default_nettype wire

@@ rtl/fbpa_datapath.sv @@
// ----------------------------------------------------------------------------
// fbpa_datapath
// Configuration registers, free stack memory with its low-water mark, shared
// multiplier, range check, divider, stack scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_datapath #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  input  wire [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [fbpa_pkg::ADDR_W-1:0]     cfg_data_i,
  input  wire                            req_type_i,
  input  wire [fbpa_pkg::ADDR_W-1:0]     free_addr_i,
  input  wire                            out_ready_i,
  input  fbpa_pkg::cmd_t                 cmd_i,
  output fbpa_pkg::stat_t                stat_o,
  output logic                           out_valid_o,
  output logic [2:0]                     status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]    block_addr_o,
  output logic [fbpa_pkg::COUNT_W-1:0]   free_left_o
);
  import fbpa_pkg::*;

  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int MUL_A_W     = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int PROD_W      = MUL_A_W + SIZE_W;
  localparam int COUNT_RST_P = (MAX_BLOCKS < COUNT_RST) ? MAX_BLOCKS : COUNT_RST;

  // configuration
  logic [ADDR_W-1:0]  base_q;
  logic [SIZE_W-1:0]  size_q;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_cap;

  // stack bookkeeping; positions below lw_q were never written since reinit
  logic [COUNT_W-1:0] fc_q, fc_d;
  logic [COUNT_W-1:0] lw_q, lw_d;
  logic [COUNT_W-1:0] fc_dec;

  // current request
  logic               req_q;
  logic [ADDR_W-1:0]  faddr_q;
  logic [ADDR_W-1:0]  baddr_q;
  logic [PROD_W-1:0]  prod_q;

  // memory read port
  logic [IDX_W-1:0]   stack_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]   rd_pos_q;
  logic               rd_init_q;
  logic               rd_vld_q;
  logic               rd_en;
  logic [COUNT_W-1:0] rd_pos;
  logic [IDX_W-1:0]   entry;

  // scan
  logic [COUNT_W-1:0] scan_q;
  logic               scan_more;
  logic               hit;
  logic               issue;

  // arithmetic
  logic [MUL_A_W-1:0] mul_a;
  logic [ADDR_W:0]    end_w;
  logic [ADDR_W-1:0]  offset;
  logic               out_range;

  // divider
  logic               div_done;
  logic [COUNT_W-1:0] quo;
  logic               rem_zero;

  // result register
  logic               out_valid_q;
  status_e            status_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COUNT_W-1:0] free_left_q;

  // block_count write saturates at capacity
  always_comb begin
    count_cap = cfg_data_i[COUNT_W-1:0];
    if (int'(cfg_data_i[COUNT_W-1:0]) > MAX_BLOCKS) begin
      count_cap = COUNT_W'(MAX_BLOCKS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      size_q  <= SIZE_W'(SIZE_RST);
      count_q <= COUNT_W'(COUNT_RST_P);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POOL_BASE:   base_q  <= cfg_data_i;
        CFG_BLOCK_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_BLOCK_COUNT: count_q <= count_cap;
        default: ;
      endcase
    end
  end

  // free count and low-water mark
  assign fc_dec = fc_q - 1'b1;

  always_comb begin
    fc_d = fc_q;
    lw_d = lw_q;
    if (cfg_valid_i && (cfg_index_i == CFG_BLOCK_COUNT)) begin
      fc_d = count_cap;
      lw_d = count_cap;
    end else if (cmd_i.pop) begin
      fc_d = fc_dec;
      if (fc_dec < lw_q) begin
        lw_d = fc_dec;
      end
    end else if (cmd_i.push) begin
      fc_d = fc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= COUNT_W'(COUNT_RST_P);
      lw_q <= COUNT_W'(COUNT_RST_P);
    end else begin
      fc_q <= fc_d;
      lw_q <= lw_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      faddr_q <= free_addr_i;
    end
  end

  // block address, zero unless an allocation sets it
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      baddr_q <= '0;
    end else if (cmd_i.set_addr) begin
      baddr_q <= base_q + ADDR_W'(prod_q);
    end
  end

  // stack entry seen through the low-water mark
  assign entry = rd_init_q ? rd_pos_q : rd_data_q;

  // shared multiplier
  assign mul_a = cmd_i.mul_count ? MUL_A_W'(count_q) : MUL_A_W'(entry);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_count || cmd_i.mul_entry) begin
      prod_q <= mul_a * PROD_W'(size_q);
    end
  end

  // range check against base + count * size, exclusive end
  assign end_w     = {1'b0, base_q} + (ADDR_W + 1)'(prod_q);
  assign out_range = (faddr_q < base_q) || ({1'b0, faddr_q} >= end_w);
  assign offset    = faddr_q - base_q;

  fbpa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (offset[REM_W-1:0]),
    .divisor_i  (size_q),
    .done_o     (div_done),
    .quotient_o (quo),
    .rem_zero_o (rem_zero)
  );

  // scan of the live part of the stack, one read per cycle
  assign scan_more = scan_q < fc_q;
  assign hit       = rd_vld_q && (MUL_A_W'(entry) == MUL_A_W'(quo));
  assign issue     = cmd_i.scan_step && !hit && scan_more;
  assign rd_en     = cmd_i.pop || issue;
  assign rd_pos    = cmd_i.pop ? fc_dec : scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[IDX_W'(fc_q)] <= IDX_W'(quo);
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[IDX_W'(rd_pos)];
      rd_pos_q  <= IDX_W'(rd_pos);
      rd_init_q <= rd_pos < lw_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_q    <= cmd_i.code;
      out_addr_q  <= baddr_q;
      free_left_q <= fc_q;
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.req_free    = (req_q == REQ_FREE);
    stat_o.is_null     = (faddr_q == '0);
    stat_o.out_range   = out_range;
    stat_o.div_done    = div_done;
    stat_o.misalign    = !rem_zero;
    stat_o.scan_hit    = hit;
    stat_o.scan_end    = !scan_more && !rd_vld_q;
    stat_o.stack_full  = (fc_q >= count_q);
    stat_o.stack_empty = (fc_q == '0);
    stat_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign block_addr_o = out_addr_q;
  assign free_left_o  = free_left_q;

endmodule

`default_nettype wire

@@ rtl/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: walks an allocate or free request through the datapath
// checks in order and hands the status code to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  fbpa_pkg::stat_t  stat_i,
  output fbpa_pkg::cmd_t   cmd_o
);
  import fbpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_RD,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_FREE_MUL,
    S_FREE_RANGE,
    S_DIV,
    S_DIV_CHK,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.code = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = stat_i.req_free ? S_FREE_MUL : S_ALLOC_RD;
      end
      S_ALLOC_RD: begin
        if (stat_i.stack_empty) begin
          code_d  = ST_EMPTY;
          state_d = S_RESULT;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_ALLOC_MUL;
        end
      end
      S_ALLOC_MUL: begin
        cmd_o.mul_entry = 1'b1;
        state_d         = S_ALLOC_ADD;
      end
      S_ALLOC_ADD: begin
        cmd_o.set_addr = 1'b1;
        code_d         = ST_ALLOC;
        state_d        = S_RESULT;
      end
      S_FREE_MUL: begin
        if (stat_i.is_null) begin
          code_d  = ST_NULL;
          state_d = S_RESULT;
        end else begin
          cmd_o.mul_count = 1'b1;
          state_d         = S_FREE_RANGE;
        end
      end
      S_FREE_RANGE: begin
        if (stat_i.out_range) begin
          code_d  = ST_RANGE;
          state_d = S_RESULT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_DIV_CHK;
        end
      end
      S_DIV_CHK: begin
        if (stat_i.misalign) begin
          code_d  = ST_MISALIGN;
          state_d = S_RESULT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          code_d  = ST_DUP;
          state_d = S_RESULT;
        end else if (stat_i.scan_end) begin
          if (stat_i.stack_full) begin
            code_d = ST_FULL;
          end else begin
            cmd_o.push = 1'b1;
            code_d     = ST_FREED;
          end
          state_d = S_RESULT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered status code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_ALLOC;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

@@ rtl/fixed_block_pool_allocator.sv @@
// Allocate: the request passes dispatch, the stack pop, the multiply and the address add, and
//   is then loaded into the result register once it is free. Free: the divider and then the
//   duplicate scan, which reads one free-stack entry per cycle from the single read port.
// One request in flight; the next is taken once the sequencer is back in idle,
//   while the previous result may still wait in the output register.
// Reset is asynchronous; entry i reads as i through a low-water mark, no reset stall.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a free stack of block indices, allocate and
// checked free requests, and a register port for base, size and count.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration writes
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [fbpa_pkg::ADDR_W-1:0]     cfg_data_i,
  // request channel
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            req_type_i,
  input  wire [fbpa_pkg::ADDR_W-1:0]     free_addr_i,
  // result channel
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [2:0]                     status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]    block_addr_o,
  output logic [fbpa_pkg::COUNT_W-1:0]   free_left_o
);
  import fbpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .free_addr_i  (free_addr_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .block_addr_o (block_addr_o),
    .free_left_o  (free_left_o)
  );

`ifndef SYNTHESIS
  // one request at a time: no new request right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // stack push and pop are exclusive
  a_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.push && cmd.pop))
    else $error("free stack push and pop in the same cycle");

  // only an allocation carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_ALLOC)) |-> (block_addr_o == '0))
    else $error("nonzero block address on a non-allocate result");

  // a result is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd.load_result)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/sv/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_checker
// Watches the register, request and result channels of the block pool
// allocator and keeps its own copy of the pool registers and free stack.
// Each accepted request is turned into a predicted result, and each accepted
// result is compared field by field with the oldest open prediction.
// ----------------------------------------------------------------------------
module fbpa_checker #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          req_type_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   free_addr_i,
  // result channel
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [2:0]                    status_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   block_addr_i,
  input  logic [fbpa_pkg::COUNT_W-1:0]  free_left_i,
  // totals for the testbench top
  output int                            errors_o,
  output int                            outstanding_o,
  output int                            checked_o
);

  import fbpa_pkg::*;

  localparam int IDX_W     = $clog2(MAX_BLOCKS);
  localparam int PRINT_CAP = 60;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] left;
  } pool_result_t;

  // predicted pool registers and free stack
  logic [ADDR_W-1:0]  base_m;
  logic [SIZE_W-1:0]  size_m;
  logic [COUNT_W-1:0] count_m;
  logic [COUNT_W-1:0] free_m;
  logic [IDX_W-1:0]   stack_m [MAX_BLOCKS];

  pool_result_t expected_results [$];
  pool_result_t oldest;
  int errors  = 0;
  int checked = 0;
  int printed = 0;

  assign errors_o  = errors;
  assign checked_o = checked;

  // all blocks free again, entry i holds index i
  function automatic void refill_stack();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      stack_m[i] = IDX_W'(i);
    end
    free_m = count_m;
  endfunction

  // outcome of one request, updating the predicted stack
  function automatic pool_result_t next_pool_result(input logic kind,
                                                    input logic [ADDR_W-1:0] addr);
    pool_result_t       res;
    logic [33:0]        pool_end;
    logic [REM_W-1:0]   offset;
    logic [REM_W-1:0]   idx;
    logic               on_stack;
    res.status = ST_ALLOC;
    res.addr   = '0;
    if (kind == REQ_ALLOC) begin
      if (free_m == 0 || free_m > MAX_BLOCKS) begin
        res.status = ST_EMPTY;
      end else begin
        free_m   = free_m - 1'b1;
        res.addr = base_m + ADDR_W'(stack_m[free_m]) * ADDR_W'(size_m);
      end
    end else if (addr == '0) begin
      // zero is null even when the pool starts at zero
      res.status = ST_NULL;
    end else begin
      // exact upper bound, no wrap at 32 bits
      pool_end = {2'b00, base_m} + 34'(count_m) * 34'(size_m);
      if (addr < base_m || {2'b00, addr} >= pool_end) begin
        res.status = ST_RANGE;
      end else begin
        // inside the pool, so size and count are both nonzero
        offset = REM_W'(addr - base_m);
        if (offset % REM_W'(size_m) != 0) begin
          res.status = ST_MISALIGN;
        end else begin
          idx      = offset / REM_W'(size_m);
          on_stack = 1'b0;
          for (int i = 0; i < int'(free_m) && i < MAX_BLOCKS; i++) begin
            if (REM_W'(stack_m[i]) == idx) on_stack = 1'b1;
          end
          if (on_stack) begin
            res.status = ST_DUP;
          end else if (free_m >= count_m || free_m >= MAX_BLOCKS) begin
            res.status = ST_FULL;
          end else begin
            stack_m[free_m] = IDX_W'(idx);
            free_m          = free_m + 1'b1;
            res.status      = ST_FREED;
          end
        end
      end
    end
    res.left = free_m;
    return res;
  endfunction

  task automatic log_mismatch(input string what, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
    errors++;
    if (printed < PRINT_CAP) begin
      printed++;
      $display("[%0t] %s: expected 0x%0h, got 0x%0h (result %0d)",
               $time, what, want, got, checked);
    end
  endtask

  // channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_m  = '0;
      size_m  = SIZE_W'(SIZE_RST);
      count_m = COUNT_W'((COUNT_RST > MAX_BLOCKS) ? MAX_BLOCKS : COUNT_RST);
      refill_stack();
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      // register writes, which the user must make only while the pool is idle; the checker does not enforce it
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_POOL_BASE:  base_m = cfg_data_i;
          CFG_BLOCK_SIZE: size_m = cfg_data_i[SIZE_W-1:0];
          CFG_BLOCK_COUNT: begin
            // counts above capacity saturate
            count_m = (cfg_data_i[COUNT_W-1:0] > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS)
                                                             : cfg_data_i[COUNT_W-1:0];
            refill_stack();
          end
          default: ;
        endcase
      end
      // results first, so a stray result never pairs with a fresh request
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          log_mismatch("result with no open request", '0, block_addr_i);
        end else begin
          oldest = expected_results.pop_front();
          checked++;
          if (status_i !== oldest.status) begin
            log_mismatch("status", ADDR_W'(oldest.status), ADDR_W'(status_i));
          end
          if (block_addr_i !== oldest.addr) begin
            log_mismatch("block_addr", oldest.addr, block_addr_i);
          end
          if (free_left_i !== oldest.left) begin
            log_mismatch("free_left", ADDR_W'(oldest.left), ADDR_W'(free_left_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(next_pool_result(req_type_i, free_addr_i));
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

@@ tb/sv/fixed_block_pool_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Drives register writes and alloc/free requests into the block pool
// allocator: a directed pass over the range, alignment, duplicate, null,
// empty and saturation corners, then random pool settings with frees drawn
// most often from live blocks. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;

  import fbpa_pkg::*;

  localparam int MAX_BLOCKS   = MAX_BLOCKS_DEF;
  localparam int ITEMS_TARGET = 570;
  localparam int IDLE_LIMIT   = 10000;
  localparam int DRAIN_CYCLES = 1100;
  localparam int HOLD_CYCLES  = 300;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic                 req_type  = REQ_ALLOC;
  logic [ADDR_W-1:0]    free_addr = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  logic [2:0]           rsp_status;
  logic [ADDR_W-1:0]    rsp_addr;
  logic [COUNT_W-1:0]   rsp_left;

  int mismatches;
  int open_requests;
  int results_checked;

  // shadow of the pool setting, used to aim free addresses and to size request runs
  logic [ADDR_W-1:0] cur_base  = '0;
  int unsigned       cur_size  = SIZE_RST;
  int unsigned       cur_count = COUNT_RST;
  logic [ADDR_W-1:0] live_q [$];
  logic [ADDR_W-1:0] freed_q [$];

  int n_sent      = 0;
  int n_settings  = 1;
  int idle_cycles = 0;
  int status_seen [8];
  bit hold_req    = 1'b0;

  always #2 clk = ~clk;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (req_valid),
    .in_ready_o   (req_ready),
    .req_type_i   (req_type),
    .free_addr_i  (free_addr),
    .out_valid_o  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .status_o     (rsp_status),
    .block_addr_o (rsp_addr),
    .free_left_o  (rsp_left)
  );

  fbpa_checker #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (req_valid),
    .in_ready_i    (req_ready),
    .req_type_i    (req_type),
    .free_addr_i   (free_addr),
    .out_valid_i   (rsp_valid),
    .out_ready_i   (rsp_ready),
    .status_i      (rsp_status),
    .block_addr_i  (rsp_addr),
    .free_left_i   (rsp_left),
    .errors_o      (mismatches),
    .outstanding_o (open_requests),
    .checked_o     (results_checked)
  );

  // watchdog: ends the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // collect allocated addresses and the status mix
  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) begin
      status_seen[rsp_status]++;
      if (rsp_status == ST_ALLOC) live_q.push_back(rsp_addr);
    end
  end

  // result side: stretches of open, random, sparse or toggling ready
  initial begin : result_sink
    int         hold_left;
    int         stretch;
    sink_mode_e mode;
    hold_left = 0;
    stretch   = 0;
    mode      = SINK_OPEN;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = sink_mode_e'($urandom_range(0, 3));
          stretch = $urandom_range(8, 80);
        end
        stretch--;
        case (mode)
          SINK_OPEN:   rsp_ready <= 1'b1;
          SINK_RANDOM: rsp_ready <= ($urandom_range(0, 1) == 1);
          SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
          default:     rsp_ready <= ~rsp_ready;
        endcase
      end
    end
  end

  // one register write, then the shadow follows it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_POOL_BASE:   cur_base = data;
      CFG_BLOCK_SIZE:  cur_size = data[SIZE_W-1:0];
      CFG_BLOCK_COUNT: begin
        cur_count = (data[COUNT_W-1:0] > MAX_BLOCKS) ? MAX_BLOCKS : data[COUNT_W-1:0];
      end
      default: ;
    endcase
    live_q.delete();
    freed_q.delete();
  endtask

  // one request; valid stays high after acceptance until lowered
  task automatic send_req(input logic kind, input logic [ADDR_W-1:0] addr);
    req_valid <= 1'b1;
    req_type  <= kind;
    free_addr <= addr;
    do begin
      @(posedge clk);
    end while (!req_ready);
    n_sent++;
  endtask

  // stop offering and wait for every open request to answer
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (open_requests != 0) @(posedge clk);
  endtask

  // free address: live blocks most often, then repeats, neighbors and noise
  function automatic logic [ADDR_W-1:0] pick_free_target();
    int                r;
    int unsigned       k;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    k = (cur_count == 0) ? 0 : $urandom_range(0, cur_count - 1);
    if (r < 45 && live_q.size() > 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      freed_q.push_back(a);
      if (freed_q.size() > 8) void'(freed_q.pop_front());
    end else if (r < 55 && freed_q.size() > 0) begin
      a = freed_q[$urandom_range(0, freed_q.size() - 1)];
    end else if (r < 68) begin
      a = cur_base + k * cur_size;
    end else if (r < 78) begin
      a = cur_base + k * cur_size + ((cur_size > 1) ? $urandom_range(1, cur_size - 1) : 1);
    end else if (r < 85) begin
      a = cur_base + cur_count * cur_size + $urandom_range(0, 255);
    end else if (r < 90) begin
      a = cur_base - $urandom_range(1, 64);
    end else if (r < 94) begin
      a = '0;
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  initial begin : stimulus
    int                 r;
    int                 phase;
    int                 n_items;
    int                 burst_left;
    int                 gap;
    logic [SIZE_W-1:0]  size_raw;
    logic [COUNT_W-1:0] count_raw;
    logic [ADDR_W-1:0]  junk;
    logic [ADDR_W-1:0]  base_val;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pool: base 0, 16-byte blocks, 1024 blocks all free
    send_req(REQ_FREE, 32'h0000_0000);
    send_req(REQ_ALLOC, $urandom);
    send_req(REQ_FREE, 32'h0000_3FF0);
    send_req(REQ_FREE, 32'h0000_3FF0);
    send_req(REQ_FREE, 32'h0000_4000);
    send_req(REQ_FREE, 32'h0000_3FF8);
    send_req(REQ_FREE, 32'hFFFF_FFFF);
    settle();

    // pool crossing 4 GiB, block size 4096 with junk upper bits, count above capacity
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFF0);
    write_reg(CFG_BLOCK_SIZE, 32'hFFFF_F000);
    write_reg(CFG_BLOCK_COUNT, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, $urandom);
    send_req(REQ_FREE, 32'hFFFF_FFF0);
    send_req(REQ_FREE, 32'hFFFF_FFEF);
    send_req(REQ_FREE, 32'hFFFF_FFFF);
    send_req(REQ_FREE, 32'h003F_EFF0);
    settle();

    // no blocks at all
    write_reg(CFG_BLOCK_COUNT, 32'h0000_0000);
    send_req(REQ_ALLOC, $urandom);
    send_req(REQ_FREE, 32'h0000_1234);
    send_req(REQ_FREE, 32'h0000_0000);
    settle();

    // zero block size spans no bytes
    write_reg(CFG_POOL_BASE, 32'h0000_0100);
    write_reg(CFG_BLOCK_SIZE, 32'h0000_0000);
    write_reg(CFG_BLOCK_COUNT, 32'h0000_0004);
    write_reg(CFG_UNUSED, 32'hA5A5_5A5A);
    send_req(REQ_ALLOC, $urandom);
    send_req(REQ_FREE, 32'h0000_0100);
    settle();

    // single block at the very top of the address space
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_BLOCK_SIZE, 32'h0000_0001);
    write_reg(CFG_BLOCK_COUNT, 32'h0000_0001);
    send_req(REQ_ALLOC, $urandom);
    send_req(REQ_ALLOC, $urandom);
    send_req(REQ_FREE, 32'hFFFF_FFFF);
    send_req(REQ_FREE, 32'hFFFF_FFFF);
    settle();
    n_settings += 4;

    // random pool settings, each followed by a run of requests
    phase = 0;
    while (n_sent < ITEMS_TARGET) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 20) base_val = '0;
      else if (r < 30) base_val = 32'hFFFF_FFFF - $urandom_range(0, 65536);
      else if (r < 35) base_val = 32'hFFFF_FFFF;
      else base_val = $urandom;
      r = $urandom_range(0, 99);
      if (r < 10) size_raw = 13'd1;
      else if (r < 20) size_raw = 13'd4096;
      else if (r < 24) size_raw = 13'd0;
      else if (r < 27) size_raw = 13'h1FFF;
      else if (r < 47) size_raw = 13'(1 << $urandom_range(0, 12));
      else size_raw = 13'($urandom_range(1, 4096));
      r = $urandom_range(0, 99);
      if (r < 10) count_raw = 11'd1024;
      else if (r < 15) count_raw = 11'h7FF;
      else if (r < 19) count_raw = 11'd0;
      else if (r < 24) count_raw = 11'($urandom_range(25, 1023));
      else if (r < 27) count_raw = 11'd1025;
      else count_raw = 11'($urandom_range(1, 24));
      write_reg(CFG_POOL_BASE, base_val);
      junk = $urandom;
      write_reg(CFG_BLOCK_SIZE, ($urandom_range(0, 2) == 0) ?
                {junk[ADDR_W-1:SIZE_W], size_raw} : ADDR_W'(size_raw));
      // now and then keep the stack and move only base and size
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        junk = $urandom;
        write_reg(CFG_BLOCK_COUNT, ($urandom_range(0, 2) == 0) ?
                  {junk[ADDR_W-1:COUNT_W], count_raw} : ADDR_W'(count_raw));
      end
      n_settings++;

      n_items    = (cur_count > 24) ? $urandom_range(8, 20) : $urandom_range(20, 60);
      burst_left = 0;
      // long result stall while requests keep coming
      if (phase == 1) begin
        hold_req   = 1'b1;
        burst_left = 12;
      end
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 39) == 0) settle();
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 99) < 15) ? $urandom_range(10, 40) : $urandom_range(0, 6);
          if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if ($urandom_range(0, 99) < 48) send_req(REQ_ALLOC, $urandom);
        else send_req(REQ_FREE, pick_free_target());
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests under %0d pool settings, %0d results checked",
             n_sent, n_settings, results_checked);
    $display("status mix: alloc %0d empty %0d freed %0d null %0d range %0d misalign %0d dup %0d",
             status_seen[ST_ALLOC], status_seen[ST_EMPTY], status_seen[ST_FREED],
             status_seen[ST_NULL], status_seen[ST_RANGE], status_seen[ST_MISALIGN],
             status_seen[ST_DUP]);
    if (mismatches == 0 && open_requests == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
